// ===== rtl/core/lif_pkg.sv =====
package lif_pkg;

  localparam int ACC_W  = 40;
  localparam int PROD_W = 24;
  localparam int MEM_W  = 32;
  localparam int POT_W  = 16;
  localparam int GAIN_W = 16;
  localparam int STEP_W = 4;
  localparam int THR_W  = 15;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] CFG_STEP_COUNT      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DECAY_GAIN      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_FIRE_THRESHOLD  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_CURRENT_SCALE   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_STEP_RECIPROCAL = 3'd4;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [GAIN_W-1:0] decay_gain;
    logic [THR_W-1:0]  fire_threshold;
    logic [GAIN_W-1:0] current_scale;
    logic [GAIN_W-1:0] step_reciprocal;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CUR_MUL,
    B_CUR_RND,
    B_STEP_MUL,
    B_STEP_ADD,
    B_OUT_MUL,
    B_OUT_RND,
    B_PUSH
  } back_state_t;

endpackage

// ===== rtl/core/lif_fifo.sv =====
module lif_fifo #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/lif_front.sv =====
module lif_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [7:0]                 in_weight,
  input  logic signed [15:0]                in_activation,
  input  logic                              in_last,
  input  logic                              q_full,
  output logic                              q_push,
  output logic signed [lif_pkg::ACC_W-1:0]  q_data
);

  logic                                s1_valid_r, s1_valid_nxt;
  logic                                s1_last_r;
  logic signed [lif_pkg::PROD_W-1:0]   s1_prod_r;
  logic signed [lif_pkg::PROD_W-1:0]   prod;
  logic signed [lif_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [lif_pkg::ACC_W:0]      sum;
  logic signed [lif_pkg::ACC_W-1:0]    acc_sat;
  logic                                s1_go, s1_load;

  assign prod = in_weight * in_activation;

  // A last element must find room in the sum queue before it can retire.
  assign s1_go   = s1_valid_r && !(s1_last_r && q_full);
  assign in_full = s1_valid_r && !s1_go;
  assign s1_load = in_push && !in_full;

  assign sum = {acc_r[lif_pkg::ACC_W-1], acc_r} + (lif_pkg::ACC_W + 1)'(s1_prod_r);

  always_comb begin
    if (sum[lif_pkg::ACC_W] != sum[lif_pkg::ACC_W-1]) begin
      acc_sat = sum[lif_pkg::ACC_W] ? {1'b1, {(lif_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(lif_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum[lif_pkg::ACC_W-1:0];
    end
  end

  assign q_push = s1_go && s1_last_r;
  assign q_data = acc_sat;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    acc_nxt      = acc_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      acc_nxt      = s1_last_r ? '0 : acc_sat;
    end
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prod_r <= prod;
      s1_last_r <= in_last;
    end
  end

endmodule

// ===== rtl/core/lif_back.sv =====
module lif_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lif_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  logic signed [lif_pkg::ACC_W-1:0]  q_data,
  output logic                              q_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output logic [lif_pkg::POT_W:0]           res_data
);

  localparam int PW = lif_pkg::ACC_W + lif_pkg::GAIN_W + 1;
  localparam int RW = PW - 16;

  lif_pkg::back_state_t state_r, state_nxt;

  logic signed [lif_pkg::ACC_W-1:0]  acc_r;
  logic signed [lif_pkg::MEM_W-1:0]  cur_r;
  logic signed [lif_pkg::MEM_W-1:0]  v_r;
  logic [lif_pkg::STEP_W-1:0]        cnt_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [lif_pkg::POT_W-1:0]  pot_r;
  logic                              sat_r;

  logic signed [lif_pkg::ACC_W-1:0]  mul_a;
  logic [lif_pkg::GAIN_W-1:0]        mul_b;
  logic signed [PW-1:0]              mul_p;
  logic signed [PW-1:0]              prod_bias;
  logic signed [RW-1:0]              rnd;
  logic signed [RW:0]                step_sum;
  logic signed [lif_pkg::MEM_W-1:0]  cur_val;
  logic signed [lif_pkg::MEM_W-1:0]  step_val;
  logic signed [lif_pkg::MEM_W-1:0]  step_next;
  logic signed [lif_pkg::POT_W-1:0]  pot_val;
  logic                              pot_sat;
  logic                              last_step;

  function automatic logic signed [lif_pkg::MEM_W-1:0] sat32(input logic signed [RW:0] x);
    logic signed [RW:0] hi;
    logic signed [RW:0] lo;
    hi = (RW + 1)'({1'b0, {(lif_pkg::MEM_W-1){1'b1}}});
    lo = -hi - 1'b1;
    if (x > hi) begin
      return {1'b0, {(lif_pkg::MEM_W-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(lif_pkg::MEM_W-1){1'b0}}};
    end else begin
      return x[lif_pkg::MEM_W-1:0];
    end
  endfunction

  // One shared signed-by-unsigned multiplier serves every gain.
  assign mul_p     = mul_a * $signed({1'b0, mul_b});
  // Taking the upper bits of the biased product is a floor division by 2^16.
  assign prod_bias = prod_r + PW'(32768);
  assign rnd       = prod_bias[PW-1:16];

  assign cur_val   = sat32({rnd[RW-1], rnd});
  assign step_sum  = {rnd[RW-1], rnd} + (RW + 1)'(cur_r);
  assign step_val  = sat32(step_sum);
  assign step_next = (step_val >= $signed({{(lif_pkg::MEM_W-lif_pkg::THR_W){1'b0}},
                                           cfg.fire_threshold})) ? '0 : step_val;
  assign last_step = (cnt_r == cfg.step_count - 1'b1);

  always_comb begin
    pot_sat = 1'b1;
    if (rnd > RW'(32767)) begin
      pot_val = 16'sh7fff;
    end else if (rnd < -RW'(32768)) begin
      pot_val = 16'sh8000;
    end else begin
      pot_val = rnd[lif_pkg::POT_W-1:0];
      pot_sat = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lif_pkg::B_IDLE:     if (!q_empty) state_nxt = lif_pkg::B_CUR_MUL;
      lif_pkg::B_CUR_MUL:  state_nxt = lif_pkg::B_CUR_RND;
      lif_pkg::B_CUR_RND: begin
        state_nxt = (cfg.step_count == '0) ? lif_pkg::B_OUT_MUL : lif_pkg::B_STEP_MUL;
      end
      lif_pkg::B_STEP_MUL: state_nxt = lif_pkg::B_STEP_ADD;
      lif_pkg::B_STEP_ADD: begin
        state_nxt = last_step ? lif_pkg::B_OUT_MUL : lif_pkg::B_STEP_MUL;
      end
      lif_pkg::B_OUT_MUL:  state_nxt = lif_pkg::B_OUT_RND;
      lif_pkg::B_OUT_RND:  state_nxt = lif_pkg::B_PUSH;
      lif_pkg::B_PUSH:     if (!res_full) state_nxt = lif_pkg::B_IDLE;
      default:             state_nxt = lif_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    res_push = 1'b0;
    mul_a    = acc_r;
    mul_b    = cfg.current_scale;
    case (state_r)
      lif_pkg::B_IDLE:     q_pop = !q_empty;
      lif_pkg::B_STEP_MUL: begin
        mul_a = lif_pkg::ACC_W'(v_r);
        mul_b = cfg.decay_gain;
      end
      lif_pkg::B_OUT_MUL: begin
        mul_a = lif_pkg::ACC_W'(v_r);
        mul_b = cfg.step_reciprocal;
      end
      lif_pkg::B_PUSH:     res_push = !res_full;
      default: begin
        mul_a = acc_r;
        mul_b = cfg.current_scale;
      end
    endcase
  end

  assign res_data = {sat_r, pot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lif_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      lif_pkg::B_IDLE:     acc_r <= q_data;
      lif_pkg::B_CUR_RND: begin
        cur_r <= cur_val;
        v_r   <= '0;
        cnt_r <= '0;
      end
      lif_pkg::B_STEP_ADD: begin
        v_r   <= step_next;
        cnt_r <= cnt_r + 1'b1;
      end
      lif_pkg::B_OUT_RND: begin
        pot_r <= pot_val;
        sat_r <= pot_sat;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/lif_neuron_dot_accumulate.sv =====
// Leaky integrate-and-fire neuron with a streamed dot product. The front part
// takes one weight/activation pair per cycle, multiplies it and adds it into a
// saturating 40-bit sum; the element marked last sends the sum into a small
// queue and clears it. The back part then runs each queued sum through one
// shared multiplier: current scaling, step_count leak/integrate steps with the
// fire-threshold reset, and the final reciprocal scaling to a saturated Q4.12
// potential. The back part takes a new sum only once the last result is
// pushed, and each step is a multiply state then an add state; the front
// part stalls only when QUEUE_DEPTH neuron sums are waiting. Results wait
// in a RESULT_DEPTH entry queue until popped.
module lif_neuron_dot_accumulate #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [7:0]                 in_weight,
  input  logic signed [15:0]                in_activation,
  input  logic                              in_last,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [15:0]                out_potential,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lif_pkg::IDX_W-1:0]         cfg_index,
  input  logic [15:0]                       cfg_data
);

  lif_pkg::cfg_t                      cfg_r, cfg_nxt;
  logic                               q_push, q_pop, q_full, q_empty;
  logic signed [lif_pkg::ACC_W-1:0]   q_wr_data;
  logic [lif_pkg::ACC_W-1:0]          q_rd_data;
  logic                               res_push, res_full;
  logic [lif_pkg::POT_W:0]            res_wr_data, res_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lif_pkg::CFG_STEP_COUNT:      cfg_nxt.step_count = cfg_data[lif_pkg::STEP_W-1:0];
        lif_pkg::CFG_DECAY_GAIN:      cfg_nxt.decay_gain = cfg_data;
        lif_pkg::CFG_FIRE_THRESHOLD:  cfg_nxt.fire_threshold = cfg_data[lif_pkg::THR_W-1:0];
        lif_pkg::CFG_CURRENT_SCALE:   cfg_nxt.current_scale = cfg_data;
        lif_pkg::CFG_STEP_RECIPROCAL: cfg_nxt.step_reciprocal = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_count      <= 4'd3;
      cfg_r.decay_gain      <= 16'd52429;
      cfg_r.fire_threshold  <= 15'd2048;
      cfg_r.current_scale   <= 16'd655;
      cfg_r.step_reciprocal <= 16'd21845;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lif_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_weight     (in_weight),
    .in_activation (in_activation),
    .in_last       (in_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  lif_fifo #(
    .WIDTH (lif_pkg::ACC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_sum_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  lif_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   ($signed(q_rd_data)),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wr_data)
  );

  lif_fifo #(
    .WIDTH (lif_pkg::POT_W + 1),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr_data),
    .pop     (out_pop),
    .rd_data (res_rd_data),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_potential = $signed(res_rd_data[lif_pkg::POT_W-1:0]);
  assign out_saturated = res_rd_data[lif_pkg::POT_W];

endmodule
